// ----- hdl/array_priority_queue_macros.svh -----
// ----------------------------------------------------------------------------
// array_priority_queue_macros
// Assertion macros for the queue RTL.
// ----------------------------------------------------------------------------
`ifndef ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define APQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define APQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/apq_pkg.sv -----
// ----------------------------------------------------------------------------
// apq_pkg
// Types, sizes and codes for the array priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package apq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 16;
  localparam int OCC_W   = 5;
  localparam int STAT_W  = 2;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;

  // request kinds
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  // occupancy field is the count modulo 2**OCC_W
  function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] c);
    logic [CNT_W+OCC_W-1:0] w;
    w = {{OCC_W{1'b0}}, c};
    return w[OCC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/apq_ram.sv -----
// ----------------------------------------------------------------------------
// apq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_ram (
  input  wire logic                    clk,
  input  wire apq_pkg::ram_wr_t        wr,
  input  wire logic [apq_pkg::IDX_W-1:0] rd_addr,
  output apq_pkg::entry_t              rd_data
);
  import apq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hdl/array_priority_queue.sv -----
// ----------------------------------------------------------------------------
// array_priority_queue
// Bounded priority queue kept unsorted in arrival order; extract-max with
// earliest-wins tie break, gap closed by shifting later entries down.
// ----------------------------------------------------------------------------
//
// Channel  Dir  tdata (low bit up)                        tuser
// s_*      in   job_priority[7:0], job_id[23:8]           req_type
// m_*      out  out_job_id[15:0], occupancy[20:16], zero  status[1:0]
//
// Insert: result written straight to the output register and valid on the
//   cycle after the transaction.
// Extract: every stored job is scanned through the single registered read
//   port, the entries after the winner are shifted down one per cycle, and
//   the result register is loaded once the output side is free.
// Reset (rst, synchronous) empties the queue; the store itself is not cleared.
// s_tready drops while an extract is in progress or a result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "array_priority_queue_macros.svh"

module array_priority_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // slave side
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [apq_pkg::S_DATA_W-1:0] s_tdata,  // job_priority, job_id
  input  wire logic                        s_tuser,  // req_type
  // master side
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [apq_pkg::M_DATA_W-1:0]     m_tdata,  // out_job_id, occupancy, pad
  output logic [apq_pkg::STAT_W-1:0]       m_tuser   // status
);
  import apq_pkg::*;

  // control state
  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  ptr, ptr_next;       // next store address to read
  logic              rd_vld, rd_vld_next; // read data in flight this cycle
  logic              out_valid, out_valid_next;

  // payload
  logic [IDX_W-1:0]  rd_idx, rd_idx_next; // address of data now on rd_data
  logic [PRIO_W-1:0] best_prio, best_prio_next;
  logic [IDX_W-1:0]  best_idx, best_idx_next;
  logic [ID_W-1:0]   best_id, best_id_next;
  logic [ID_W-1:0]   out_id, out_id_next;
  logic [STAT_W-1:0] out_status, out_status_next;
  logic [OCC_W-1:0]  out_occ, out_occ_next;

  ram_wr_t           wr;
  entry_t            rd_data;
  logic [IDX_W-1:0]  rd_addr;

  logic              s_take;
  logic              out_free;
  logic              is_full;
  logic [PRIO_W-1:0] in_prio;
  logic [ID_W-1:0]   in_id;

  // check terms
  logic              ins_stored;
  logic              empty_res;

  assign in_prio  = s_tdata[PRIO_W-1:0];
  assign in_id    = s_tdata[PRIO_W+ID_W-1:PRIO_W];
  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign s_take   = s_tvalid && s_tready;
  assign is_full  = (count == CNT_W'(DEPTH));
  assign rd_addr  = ptr[IDX_W-1:0];

  apq_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // state register and control flops
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ptr       <= ptr_next;
      rd_vld    <= rd_vld_next;
      out_valid <= out_valid_next;
    end
  end

  // payload flops, no reset needed
  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    best_prio  <= best_prio_next;
    best_idx   <= best_idx_next;
    best_id    <= best_id_next;
    out_id     <= out_id_next;
    out_status <= out_status_next;
    out_occ    <= out_occ_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    rd_vld_next     = rd_vld;
    rd_idx_next     = rd_idx;
    best_prio_next  = best_prio;
    best_idx_next   = best_idx;
    best_id_next    = best_id;
    out_id_next     = out_id;
    out_status_next = out_status;
    out_occ_next    = out_occ;
    wr              = '0;

    // result taken downstream; a new load below overrides
    out_valid_next = out_valid && !m_tready;

    case (state)
      S_IDLE: begin
        rd_vld_next = 1'b0;
        if (s_take) begin
          if (s_tuser == REQ_INSERT) begin
            out_valid_next = 1'b1;
            out_id_next    = '0;
            if (is_full) begin
              out_status_next = STAT_FULL;
              out_occ_next    = to_occ(count);
            end else begin
              wr.we           = 1'b1;
              wr.addr         = count[IDX_W-1:0];
              wr.data.prio    = in_prio;
              wr.data.id      = in_id;
              count_next      = count + CNT_W'(1);
              out_status_next = STAT_OK;
              out_occ_next    = to_occ(count + CNT_W'(1));
            end
          end else if (count == '0) begin
            out_valid_next  = 1'b1;
            out_id_next     = '0;
            out_status_next = STAT_EMPTY;
            out_occ_next    = '0;
          end else begin
            ptr_next   = '0;
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // strict compare keeps the earliest entry on ties
        if (rd_vld) begin
          if (rd_idx == '0 || rd_data.prio > best_prio) begin
            best_prio_next = rd_data.prio;
            best_idx_next  = rd_idx;
            best_id_next   = rd_data.id;
          end
        end
        if (ptr < count) begin
          ptr_next    = ptr + CNT_W'(1);
          rd_vld_next = 1'b1;
          rd_idx_next = ptr[IDX_W-1:0];
        end else begin
          rd_vld_next = 1'b0;
          if (!rd_vld) begin
            ptr_next   = CNT_W'(best_idx) + CNT_W'(1);
            state_next = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // entry read last cycle moves one place down
        if (rd_vld) begin
          wr.we   = 1'b1;
          wr.addr = rd_idx - IDX_W'(1);
          wr.data = rd_data;
        end
        if (ptr < count) begin
          ptr_next    = ptr + CNT_W'(1);
          rd_vld_next = 1'b1;
          rd_idx_next = ptr[IDX_W-1:0];
        end else begin
          rd_vld_next = 1'b0;
          if (!rd_vld) begin
            count_next = count - CNT_W'(1);
            state_next = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_id_next     = best_id;
          out_status_next = STAT_OK;
          out_occ_next    = to_occ(count);
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W-OCC_W-ID_W){1'b0}}, out_occ, out_id};
  assign m_tuser  = out_status;

  // checks
  assign ins_stored = s_take && (s_tuser == REQ_INSERT) && !is_full;
  assign empty_res  = m_tvalid && (m_tuser == STAT_EMPTY);

  `APQ_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "count beyond depth")
  `APQ_ASSERT_NEXT(a_insert_grows, ins_stored, count == $past(count) + CNT_W'(1), "insert lost")
  `APQ_ASSERT_NEXT(a_scan_count, state == S_SCAN, $stable(count), "count moved during scan")
  `APQ_ASSERT_IMPL(a_write_phase, wr.we, state == S_IDLE || state == S_SHIFT, "stray store write")
  `APQ_ASSERT_IMPL(a_empty_occ, empty_res, out_occ == '0 && out_id == '0, "empty result not zero")

endmodule

`default_nettype wire

// ----- sim/array_priority_queue_tb.sv -----
// ----------------------------------------------------------------------------
// array_priority_queue_tb
// Self-checking bench for the array priority queue: insert and extract
// transactions go in through the slave stream, and each result on the master
// stream is compared field by field against a shadow copy of the queue kept
// in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module array_priority_queue_tb;

  import apq_pkg::*;

  localparam int CALM_TAIL   = 100;   // last transactions run with no idling
  localparam int STALL_LIMIT = 5000;  // cycles with no handshake before giving up
  localparam int DRAIN_WAIT  = 60;    // longer than a full-queue extract

  typedef struct {
    logic              req;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    bit                drain;  // hold this one back until all results are in
  } job_req_t;

  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;
    logic [2:0]        pad;
  } job_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata  = '0;  // job_priority[7:0], job_id[23:8]
  logic                  s_tuser  = 1'b0;  // req_type
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;  // out_job_id[15:0], occupancy[20:16], pad
  logic [STAT_W-1:0]     m_tuser;  // status

  array_priority_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the queue contents, in arrival order
  logic [PRIO_W-1:0] shadow_prio [DEPTH];
  logic [ID_W-1:0]   shadow_id   [DEPTH];
  int                shadow_count = 0;

  job_req_t    pending_reqs[$];
  job_result_t queued_results[$];

  int mismatches   = 0;
  int inserts_done = 0;
  int extracts_done = 0;
  int full_drops   = 0;
  int empty_takes  = 0;
  int peak_count   = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int send_gap     = 0;
  int recv_gap     = 0;

  // Applies one request to the shadow queue and returns what the block
  // should answer.
  function automatic job_result_t serve_request(input logic req,
                                                input logic [PRIO_W-1:0] prio,
                                                input logic [ID_W-1:0] id);
    job_result_t r;
    int i;
    int best;
    r = '0;
    if (req == REQ_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = STAT_FULL;
        full_drops++;
      end else begin
        shadow_prio[shadow_count] = prio;
        shadow_id[shadow_count]   = id;
        shadow_count++;
        r.status = STAT_OK;
      end
    end else if (shadow_count == 0) begin
      r.status = STAT_EMPTY;
      empty_takes++;
    end else begin
      // strict compare keeps the earliest entry on ties
      best = 0;
      for (i = 1; i < shadow_count; i++)
        if (shadow_prio[i] > shadow_prio[best]) best = i;
      r.job_id = shadow_id[best];
      for (i = best; i + 1 < shadow_count; i++) begin
        shadow_prio[i] = shadow_prio[i + 1];
        shadow_id[i]   = shadow_id[i + 1];
      end
      shadow_count--;
      r.status = STAT_OK;
    end
    r.occupancy = OCC_W'(shadow_count);
    if (shadow_count > peak_count) peak_count = shadow_count;
    return r;
  endfunction

  function automatic void note_mismatch(input string field, input int want,
                                        input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: result %0d, %s mismatch: expected 0x%0h, got 0x%0h",
               $realtime, results_seen, field, want, got);
  endfunction

  task automatic add_req(input logic req, input int prio, input int id,
                         input bit drain);
    job_req_t j;
    j.req   = req;
    j.prio  = PRIO_W'(prio);
    j.id    = ID_W'(id);
    j.drain = drain;
    pending_reqs.push_back(j);
  endtask

  // Driver: presents pending requests, predicts on each accepted transaction.
  always @(posedge clk) begin
    logic     took;
    job_req_t nxt;
    took = s_tvalid && s_tready;
    if (!rst) begin
      if (took) begin
        queued_results.push_back(serve_request(s_tuser, s_tdata[PRIO_W-1:0],
                                               s_tdata[PRIO_W+ID_W-1:PRIO_W]));
        if (s_tuser == REQ_INSERT) inserts_done++;
        else extracts_done++;
      end
      if (s_tvalid && !took) begin
        // hold the current transaction
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain && queued_results.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 14) - 1;
        s_tvalid <= 1'b0;
      end else begin
        nxt = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {nxt.id, nxt.prio};
        s_tuser  <= nxt.req;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, and stalls
  // the master side in bursts.
  always @(posedge clk) begin
    job_result_t got;
    job_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.job_id    = m_tdata[ID_W-1:0];
        got.occupancy = m_tdata[ID_W+OCC_W-1:ID_W];
        got.pad       = m_tdata[M_DATA_W-1:ID_W+OCC_W];
        got.status    = m_tuser;
        if (queued_results.size() == 0) begin
          note_mismatch("unexpected result, job id", 0, got.job_id);
        end else begin
          want = queued_results.pop_front();
          if (got.job_id !== want.job_id) note_mismatch("job id", want.job_id, got.job_id);
          if (got.status !== want.status) note_mismatch("status", want.status, got.status);
          if (got.occupancy !== want.occupancy)
            note_mismatch("occupancy", want.occupancy, got.occupancy);
          if (got.pad !== want.pad) note_mismatch("tdata padding", want.pad, got.pad);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog count: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("array_priority_queue test failed");
    $finish;
  end

  initial begin
    int fill_prio [16];
    int k;
    int seg_len;
    int ins_pct;
    fill_prio = '{0, 255, 7, 255, 128, 1, 7, 254, 0, 255, 64, 7, 3, 200, 255, 2};

    // directed: empty extract, fill with ties and extremes, drop when full,
    // then take a few back out
    add_req(REQ_EXTRACT, 255, 16'hFFFF, 1'b0);
    for (k = 0; k < 16; k++)
      add_req(REQ_INSERT, fill_prio[k], (k == 0) ? 0 : (k == 1) ? 16'hFFFF : 16'h1000 + k,
              1'b0);
    add_req(REQ_INSERT, 255, 16'hFFFF, 1'b1);
    add_req(REQ_INSERT, 0, 0, 1'b0);
    for (k = 0; k < 5; k++) add_req(REQ_EXTRACT, 0, 0, 1'b0);

    // random: runs with a bias towards filling, draining or neither, so the
    // queue keeps swinging between empty and full
    while (pending_reqs.size() < 924) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: ins_pct = 25;
        1: ins_pct = 50;
        default: ins_pct = 80;
      endcase
      for (k = 0; k < seg_len; k++)
        add_req(($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_EXTRACT,
                ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255),
                $urandom_range(0, 65535), $urandom_range(0, 149) == 0);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || queued_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d inserts (%0d dropped as full), %0d extracts (%0d on empty)",
             inserts_done, full_drops, extracts_done, empty_takes);
    $display("%0d results checked, peak occupancy %0d of %0d, %0d mismatches",
             results_seen, peak_count, DEPTH, mismatches);
    if (mismatches == 0 && queued_results.size() == 0) begin
      $display("array_priority_queue test passed");
    end else begin
      $display("array_priority_queue test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
